[src/rlps_pkg.sv]
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types and constants of the RGB LED pixel serializer.
// ----------------------------------------------------------------------------
package rlps_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_LATCH     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} grb_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// floor(p / 65025) == (p * RECIP) >> RECIP_SHIFT for every p below 2**24
	localparam int RECIP_SHIFT = 40;
	localparam logic [24:0] RECIP =
		25'(((64'd1 << RECIP_SHIFT) + 64'd65024) / 64'd65025);

	localparam logic [4:0] DATA_SYMS = 5'd24;
	localparam logic [4:0] TOP_BIT   = 5'd23;

endpackage

[src/rgb_led_pixel_serializer.sv]
// ----------------------------------------------------------------------------
// rgb_led_pixel_serializer
// Turns one RGB pixel with brightness into 25 LED line symbols.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one pixel per transaction, red_in,
// green_in, blue_in and level. Each colour is scaled by level squared over
// 255 squared and sent green, red, blue, MSB first.
// Output channel (out_valid/out_ready): one line symbol per transaction,
// a high phase and a low phase in ticks; 24 data symbols then one latch
// symbol with last set.
// Path: a pixel passes the three stage scaling pipeline, the queue and
// the symbol register before its first symbol is valid.
// The symbol generator gives one symbol per cycle while out_ready allows,
// 25 symbols per pixel; a 4-entry pixel queue lets intake run ahead.
// A stalled receiver holds the current symbol; the queue fills and
// in_ready drops once all slots are taken or promised.
// Reset clears the pipeline and queue and loads the default timing.
// APB registers at 4*i: zero high, zero low, one high, one low, latch.
// ----------------------------------------------------------------------------
module rgb_led_pixel_serializer #(
	parameter int TICK_WIDTH = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rlps_pkg::ADDR_W-1:0] paddr,
	input  logic [rlps_pkg::DATA_W-1:0] pwdata,
	output logic [rlps_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 red_in,
	input  logic [7:0]                 green_in,
	input  logic [7:0]                 blue_in,
	input  logic [7:0]                 level,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       first_level,
	output logic [TICK_WIDTH-1:0]      first_ticks,
	output logic                       second_level,
	output logic [TICK_WIDTH-1:0]      second_ticks,
	output logic                       last
);

	logic [TICK_WIDTH-1:0] zero_high, zero_low, one_high, one_low, latch;
	logic [rlps_pkg::QCNT_W-1:0] q_count;
	logic q_push, q_pop, head_valid;
	rlps_pkg::grb_t q_data, head;

	assign pready       = 1'b1;
	assign second_level = 1'b0;

	rlps_regs #(.TICK_WIDTH(TICK_WIDTH)) u_regs (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.zero_high_q(zero_high), .zero_low_q(zero_low),
		.one_high_q(one_high), .one_low_q(one_low), .latch_q(latch)
	);

	rlps_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in), .level(level),
		.q_count(q_count), .q_push(q_push), .q_data(q_data)
	);

	rlps_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wr_data(q_data), .pop(q_pop),
		.head_valid(head_valid), .head(head), .count(q_count)
	);

	rlps_back #(.TICK_WIDTH(TICK_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .pop(q_pop),
		.zero_high(zero_high), .zero_low(zero_low),
		.one_high(one_high), .one_low(one_low), .latch(latch),
		.out_valid(out_valid), .out_ready(out_ready),
		.first_level(first_level), .first_ticks(first_ticks),
		.second_ticks(second_ticks), .last(last)
	);

endmodule

[src/rlps_regs.sv]
// ----------------------------------------------------------------------------
// rlps_regs
// APB register file holding the symbol timing in ticks.
// ----------------------------------------------------------------------------
module rlps_regs #(
	parameter int TICK_WIDTH = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rlps_pkg::ADDR_W-1:0] paddr,
	input  logic [rlps_pkg::DATA_W-1:0] pwdata,
	output logic [rlps_pkg::DATA_W-1:0] prdata,
	output logic [TICK_WIDTH-1:0]      zero_high_q,
	output logic [TICK_WIDTH-1:0]      zero_low_q,
	output logic [TICK_WIDTH-1:0]      one_high_q,
	output logic [TICK_WIDTH-1:0]      one_low_q,
	output logic [TICK_WIDTH-1:0]      latch_q
);

	logic                       wr_en;
	logic [TICK_WIDTH-1:0]      wr_val;
	rlps_pkg::reg_idx_t         idx;

	assign wr_en  = psel & penable & pwrite;
	assign wr_val = pwdata[TICK_WIDTH-1:0];
	assign idx    = rlps_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= TICK_WIDTH'(28);
			zero_low_q  <= TICK_WIDTH'(64);
			one_high_q  <= TICK_WIDTH'(56);
			one_low_q   <= TICK_WIDTH'(48);
			latch_q     <= TICK_WIDTH'(24000);
		end else if (wr_en) begin
			case (idx)
				rlps_pkg::REG_ZERO_HIGH: zero_high_q <= wr_val;
				rlps_pkg::REG_ZERO_LOW:  zero_low_q  <= wr_val;
				rlps_pkg::REG_ONE_HIGH:  one_high_q  <= wr_val;
				rlps_pkg::REG_ONE_LOW:   one_low_q   <= wr_val;
				rlps_pkg::REG_LATCH:     latch_q     <= wr_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rlps_pkg::REG_ZERO_HIGH: prdata = 32'(zero_high_q);
			rlps_pkg::REG_ZERO_LOW:  prdata = 32'(zero_low_q);
			rlps_pkg::REG_ONE_HIGH:  prdata = 32'(one_high_q);
			rlps_pkg::REG_ONE_LOW:   prdata = 32'(one_low_q);
			rlps_pkg::REG_LATCH:     prdata = 32'(latch_q);
			default:                 prdata = '0;
		endcase
	end

endmodule

[src/rlps_front.sv]
// ----------------------------------------------------------------------------
// rlps_front
// Pixel intake: squared brightness scaling and reordering to G, R, B.
// ----------------------------------------------------------------------------
module rlps_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 red_in,
	input  logic [7:0]                 green_in,
	input  logic [7:0]                 blue_in,
	input  logic [7:0]                 level,
	input  logic [rlps_pkg::QCNT_W-1:0] q_count,
	output logic                       q_push,
	output rlps_pkg::grb_t             q_data
);

	logic        valid_s1, valid_s2, valid_s3;
	logic [7:0]  red_s1, green_s1, blue_s1;
	logic [15:0] sq_s1;
	logic [23:0] red_s2, green_s2, blue_s2;
	rlps_pkg::grb_t pix_s3;
	logic [rlps_pkg::QCNT_W-1:0] used;
	logic        take;
	logic [48:0] rq, gq, bq;

	// queue slots already taken plus those promised to pixels in flight
	assign used = q_count + rlps_pkg::QCNT_W'(valid_s1) + rlps_pkg::QCNT_W'(valid_s2)
		+ rlps_pkg::QCNT_W'(valid_s3);
	assign in_ready = used < rlps_pkg::QCNT_W'(rlps_pkg::QDEPTH);
	assign take     = in_valid & in_ready;

	assign rq = red_s2   * rlps_pkg::RECIP;
	assign gq = green_s2 * rlps_pkg::RECIP;
	assign bq = blue_s2  * rlps_pkg::RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		red_s1   <= red_in;
		green_s1 <= green_in;
		blue_s1  <= blue_in;
		sq_s1    <= level * level;
		red_s2   <= red_s1   * sq_s1;
		green_s2 <= green_s1 * sq_s1;
		blue_s2  <= blue_s1  * sq_s1;
		pix_s3.red   <= rq[47:40];
		pix_s3.green <= gq[47:40];
		pix_s3.blue  <= bq[47:40];
	end

	assign q_push = valid_s3;
	assign q_data = pix_s3;

endmodule

[src/rlps_queue.sv]
// ----------------------------------------------------------------------------
// rlps_queue
// Small show-ahead FIFO of scaled pixels between intake and serializer.
// ----------------------------------------------------------------------------
module rlps_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rlps_pkg::grb_t             wr_data,
	input  logic                       pop,
	output logic                       head_valid,
	output rlps_pkg::grb_t             head,
	output logic [rlps_pkg::QCNT_W-1:0] count
);

	rlps_pkg::grb_t mem [rlps_pkg::QDEPTH];
	logic [rlps_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rlps_pkg::QCNT_W-1:0] count_q;
	logic do_pop;

	assign do_pop     = pop & (count_q != '0);
	assign head_valid = count_q != '0;
	assign head       = mem[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + rlps_pkg::QCNT_W'(push) - rlps_pkg::QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[src/rlps_back.sv]
// ----------------------------------------------------------------------------
// rlps_back
// Symbol generator: 24 data symbols MSB first, then the latch symbol.
// ----------------------------------------------------------------------------
module rlps_back #(
	parameter int TICK_WIDTH = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  rlps_pkg::grb_t        head,
	output logic                  pop,
	input  logic [TICK_WIDTH-1:0] zero_high,
	input  logic [TICK_WIDTH-1:0] zero_low,
	input  logic [TICK_WIDTH-1:0] one_high,
	input  logic [TICK_WIDTH-1:0] one_low,
	input  logic [TICK_WIDTH-1:0] latch,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  first_level,
	output logic [TICK_WIDTH-1:0] first_ticks,
	output logic [TICK_WIDTH-1:0] second_ticks,
	output logic                  last
);

	logic [4:0]            sym_q;
	logic                  out_valid_q;
	logic                  level_q, last_q;
	logic [TICK_WIDTH-1:0] first_q, second_q;
	logic                  gen, is_latch, bit_val;
	logic [23:0]           word;

	assign word     = head;
	assign gen      = head_valid & (~out_valid_q | out_ready);
	assign is_latch = sym_q == rlps_pkg::DATA_SYMS;
	assign bit_val  = word[rlps_pkg::TOP_BIT - sym_q];
	assign pop      = gen & is_latch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (gen) begin
				out_valid_q <= 1'b1;
				sym_q       <= is_latch ? '0 : sym_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			if (is_latch) begin
				level_q  <= 1'b0;
				first_q  <= latch;
				second_q <= '0;
				last_q   <= 1'b1;
			end else begin
				level_q  <= 1'b1;
				first_q  <= bit_val ? one_high : zero_high;
				second_q <= bit_val ? one_low : zero_low;
				last_q   <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign first_level  = level_q;
	assign first_ticks  = first_q;
	assign second_ticks = second_q;
	assign last         = last_q;

endmodule
